@@ rtl/mwm_pkg.sv @@
`timescale 1ns / 1ps

package mwm_pkg;

  // field widths
  localparam int unsigned WHEEL_W    = 16;
  localparam int unsigned AUX_W      = 19;
  localparam int unsigned COEFF_W    = 16;
  localparam int unsigned DRIVE_W    = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // heading reduction and binary angle: t = floor(u * 2^32 / 23040) = floor(u * 2^23 / 45)
  localparam int unsigned HEAD_W         = 17;
  localparam logic signed [HEAD_W-1:0] TURN_S  = 17'sd23040;
  localparam logic signed [HEAD_W-1:0] TURN2_S = 17'sd46080;
  localparam int unsigned U_W            = 15;
  localparam int unsigned ANGLE_SHIFT    = 23;
  localparam int unsigned ANGLE_DIV      = 45;
  localparam int unsigned DVD_W          = U_W + ANGLE_SHIFT;
  localparam int unsigned DIV_DIGIT      = 2;
  localparam int unsigned DIV_STEPS      = DVD_W / DIV_DIGIT;
  localparam int unsigned REM_W          = 6;
  localparam int unsigned ANG_W          = 32;
  localparam logic signed [ANG_W-1:0] ANG_QUARTER = 32'sd1073741824;

  // CORDIC, Q4.30
  localparam int unsigned CW         = 34;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
  localparam int unsigned ATAN_IDX_W = 5;
  localparam int unsigned Q15_SHIFT  = 15;
  localparam int unsigned CQ_W       = CW - Q15_SHIFT;
  localparam logic signed [CQ_W-1:0] Q15_MAX = 19'sd32767;
  localparam logic signed [CQ_W-1:0] Q15_MIN = -19'sd32768;

  // serial multiply and mixing
  localparam int unsigned MUL_STEPS = 16;
  localparam int unsigned PROD_W    = 48;
  localparam int unsigned FRAC_XY   = 23;
  localparam int unsigned FRAC_ROT  = 8;
  localparam int unsigned MAG_W     = 25;
  localparam int unsigned SUM_W     = 27;
  localparam logic signed [SUM_W-1:0] WHEEL_MIN = -27'sd32768;
  localparam logic signed [AUX_W-1:0] AUX_FIXED = -19'sd3000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_FOLD,
    S_CORDIC,
    S_SCALE,
    S_MUL,
    S_TRUNC,
    S_MIX,
    S_FIN
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEFF_X,
    REG_COEFF_Y,
    REG_COEFF_ROT,
    REG_MAX_DRIVE,
    REG_AUX_MODE
  } reg_idx_t;

  typedef enum logic {
    OP_DRIVE,
    OP_AUX
  } op_t;

  // atan(2^-i) as a 32-bit binary angle
  function automatic logic [ANG_W-1:0] atan_angle(input logic [ATAN_IDX_W-1:0] idx);
    logic [ANG_W-1:0] a;
    case (idx)
      5'd0:    a = 32'h2000_0000;
      5'd1:    a = 32'h12E4_051E;
      5'd2:    a = 32'h09FB_385B;
      5'd3:    a = 32'h0511_11D4;
      5'd4:    a = 32'h028B_0D43;
      5'd5:    a = 32'h0145_D7E1;
      5'd6:    a = 32'h00A2_F61E;
      5'd7:    a = 32'h0051_7C55;
      5'd8:    a = 32'h0028_BE53;
      5'd9:    a = 32'h0014_5F2F;
      5'd10:   a = 32'h000A_2F98;
      5'd11:   a = 32'h0005_17CC;
      5'd12:   a = 32'h0002_8BE6;
      5'd13:   a = 32'h0001_45F3;
      5'd14:   a = 32'h0000_A2F9;
      5'd15:   a = 32'h0000_517C;
      5'd16:   a = 32'h0000_28BE;
      5'd17:   a = 32'h0000_145F;
      5'd18:   a = 32'h0000_0A2F;
      5'd19:   a = 32'h0000_0517;
      5'd20:   a = 32'h0000_028B;
      5'd21:   a = 32'h0000_0145;
      5'd22:   a = 32'h0000_00A2;
      5'd23:   a = 32'h0000_0051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/mwm_ifs.sv @@
`timescale 1ns / 1ps

interface mwm_drive_if;
  logic                                       valid;
  logic                                       ready;
  logic                                       operation;
  logic signed [mwm_pkg::WHEEL_W-1:0]         heading;
  logic signed [mwm_pkg::WHEEL_W-1:0]         speed;
  logic signed [mwm_pkg::WHEEL_W-1:0]         rotation;

  modport source (output valid, operation, heading, speed, rotation, input ready);
  modport sink (input valid, operation, heading, speed, rotation, output ready);
endinterface

interface mwm_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [mwm_pkg::WHEEL_W-1:0] front_left;
  logic signed [mwm_pkg::WHEEL_W-1:0] front_right;
  logic signed [mwm_pkg::WHEEL_W-1:0] rear_right;
  logic signed [mwm_pkg::WHEEL_W-1:0] rear_left;
  logic signed [mwm_pkg::AUX_W-1:0]   aux_one;
  logic signed [mwm_pkg::AUX_W-1:0]   aux_two;
  logic signed [mwm_pkg::AUX_W-1:0]   aux_three;
  logic signed [mwm_pkg::AUX_W-1:0]   aux_four;

  modport source (output valid, front_left, front_right, rear_right, rear_left,
                  aux_one, aux_two, aux_three, aux_four, input ready);
  modport sink (input valid, front_left, front_right, rear_right, rear_left,
                aux_one, aux_two, aux_three, aux_four, output ready);
endinterface

interface mwm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mwm_pkg::CFG_IDX_W-1:0]     index;
  logic [mwm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/mecanum_wheel_mixer_top.sv @@
`timescale 1ns / 1ps

// Four-wheel mecanum mixer.
// drive (sink): one beat per command; operation selects a full drive command
//   or an auxiliary-only update that repeats the stored wheel commands.
// result (source): one beat per command, wheel commands FL/FR/RR/RL and four
//   auxiliary values, held in an output register until taken.
// cfg (sink): register writes by index, always ready; write only while idle.
// Flow: a drive command passes through radix-4 angle division, fold,
//   CORDIC_STEPS CORDIC iterations, scale, bit-serial multiply, trunc, mix
//   and finish states before it shows on result.
//   A new beat is taken the cycle after the result is loaded, so drive
//   commands do not overlap.
//   An auxiliary-only update goes straight to the finish state.
// Only one command is in flight; the three shift-add multiplier lanes form
//   the gain products while the angle divider runs, and the CORDIC and the second multiply follow one after another.
// Reset: sync, clears the control path, the registers to their defaults and
//   the stored wheel commands to zero.
// Receiver stall: the finished result waits in the output register; the next
//   drive beat is taken and worked on, and holds in the finish state only if
//   the earlier result has still not been taken.
module mecanum_wheel_mixer_top #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input logic          clk,
  input logic          rst,
  mwm_drive_if.sink    drive,
  mwm_result_if.source result,
  mwm_cfg_if.sink      cfg
);

  localparam int unsigned STEP_MAX = (CORDIC_STEPS > mwm_pkg::DIV_STEPS) ?
                                     CORDIC_STEPS : mwm_pkg::DIV_STEPS;
  localparam int unsigned STEP_W   = $clog2(STEP_MAX);
  localparam int unsigned LANES    = 3;
  localparam int unsigned LANE_X   = 0;
  localparam int unsigned LANE_Y   = 1;
  localparam int unsigned LANE_W   = 2;

  mwm_pkg::state_t state, state_next;
  logic [STEP_W-1:0] cnt;

  // config registers
  logic [mwm_pkg::COEFF_W-1:0] coeff_x, coeff_y, coeff_rot;
  logic [mwm_pkg::DRIVE_W-1:0] max_drive;
  logic                        aux_mode;

  // control
  logic accept, accept_drive, fin_load, lane_run, mul_signed, mul_last;
  logic op_aux;

  // angle divider
  logic [mwm_pkg::DVD_W-1:0] dvd, div_dvd;
  logic [mwm_pkg::REM_W-1:0] rem, div_rem;
  logic [mwm_pkg::ANG_W-1:0] quo, div_quo;
  logic signed [mwm_pkg::HEAD_W-1:0] head_s, head_r;

  // CORDIC
  logic signed [mwm_pkg::CW-1:0]    x, y, x_f, y_f;
  logic signed [mwm_pkg::ANG_W-1:0] z, t_ang, fold_z, atan_s;
  logic                             neg, fold_neg;
  logic signed [mwm_pkg::WHEEL_W-1:0] cos_q15, sin_q15;

  // multiplier lanes
  logic signed [mwm_pkg::PROD_W-1:0] acc [LANES];
  logic signed [mwm_pkg::PROD_W-1:0] acc_next [LANES];
  logic signed [mwm_pkg::PROD_W-1:0] mcand [LANES];
  logic signed [mwm_pkg::PROD_W-1:0] mcand_next [LANES];
  logic [mwm_pkg::MUL_STEPS-1:0]     mplr [LANES];
  logic [mwm_pkg::MUL_STEPS-1:0]     mplr_next [LANES];

  // mixing
  logic signed [mwm_pkg::MAG_W-1:0]   vx, vy, w;
  logic signed [mwm_pkg::SUM_W-1:0]   s_fl, s_fr, s_rr, s_rl;
  logic signed [mwm_pkg::WHEEL_W-1:0] lw_fl, lw_fr, lw_rr, lw_rl;

  function automatic logic signed [mwm_pkg::WHEEL_W-1:0] sat_q15(
    input logic signed [mwm_pkg::CQ_W-1:0] v
  );
    if (v > mwm_pkg::Q15_MAX) begin
      return mwm_pkg::WHEEL_W'(mwm_pkg::Q15_MAX);
    end else if (v < mwm_pkg::Q15_MIN) begin
      return mwm_pkg::WHEEL_W'(mwm_pkg::Q15_MIN);
    end
    return mwm_pkg::WHEEL_W'(v);
  endfunction

  // divide by 2^sh, rounding toward zero
  function automatic logic signed [mwm_pkg::MAG_W-1:0] trunc_div(
    input logic signed [mwm_pkg::PROD_W-1:0] v,
    input logic [4:0]                        sh
  );
    logic signed [mwm_pkg::PROD_W-1:0] b;
    b = v + (v[mwm_pkg::PROD_W-1] ?
             (mwm_pkg::PROD_W'(1) << sh) - mwm_pkg::PROD_W'(1) : '0);
    return mwm_pkg::MAG_W'(b >>> sh);
  endfunction

  function automatic logic signed [mwm_pkg::WHEEL_W-1:0] clamp_wheel(
    input logic signed [mwm_pkg::SUM_W-1:0] v,
    input logic [mwm_pkg::DRIVE_W-1:0]      lim
  );
    logic signed [mwm_pkg::SUM_W-1:0] lim_s;
    lim_s = signed'(mwm_pkg::SUM_W'(lim));
    if (v > lim_s) begin
      return mwm_pkg::WHEEL_W'(lim_s);
    end else if (v < mwm_pkg::WHEEL_MIN) begin
      return mwm_pkg::WHEEL_W'(mwm_pkg::WHEEL_MIN);
    end
    return mwm_pkg::WHEEL_W'(v);
  endfunction

  function automatic logic signed [mwm_pkg::AUX_W-1:0] aux_of(
    input logic signed [mwm_pkg::WHEEL_W-1:0] wv,
    input logic                               mode,
    input logic                               fixed
  );
    if (!mode) begin
      return '0;
    end else if (fixed) begin
      return mwm_pkg::AUX_FIXED;
    end
    return -(mwm_pkg::AUX_W'(wv) <<< 2);
  endfunction

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_next = state;
    case (state)
      mwm_pkg::S_IDLE: begin
        if (drive.valid) begin
          state_next = (drive.operation == mwm_pkg::OP_AUX) ? mwm_pkg::S_FIN : mwm_pkg::S_DIV;
        end
      end
      mwm_pkg::S_DIV: begin
        if (cnt == STEP_W'(mwm_pkg::DIV_STEPS - 1)) state_next = mwm_pkg::S_FOLD;
      end
      mwm_pkg::S_FOLD:   state_next = mwm_pkg::S_CORDIC;
      mwm_pkg::S_CORDIC: begin
        if (cnt == STEP_W'(CORDIC_STEPS - 1)) state_next = mwm_pkg::S_SCALE;
      end
      mwm_pkg::S_SCALE:  state_next = mwm_pkg::S_MUL;
      mwm_pkg::S_MUL: begin
        if (cnt == STEP_W'(mwm_pkg::MUL_STEPS - 1)) state_next = mwm_pkg::S_TRUNC;
      end
      mwm_pkg::S_TRUNC:  state_next = mwm_pkg::S_MIX;
      mwm_pkg::S_MIX:    state_next = mwm_pkg::S_FIN;
      mwm_pkg::S_FIN: begin
        if (!result.valid || result.ready) state_next = mwm_pkg::S_IDLE;
      end
      default:           state_next = mwm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    drive.ready  = (state == mwm_pkg::S_IDLE);
    cfg.ready    = 1'b1;
    accept       = drive.valid && (state == mwm_pkg::S_IDLE);
    accept_drive = accept && (drive.operation == mwm_pkg::OP_DRIVE);
    fin_load     = (state == mwm_pkg::S_FIN) && (!result.valid || result.ready);
    lane_run     = ((state == mwm_pkg::S_DIV) && (cnt < STEP_W'(mwm_pkg::MUL_STEPS))) ||
                   (state == mwm_pkg::S_MUL);
    mul_signed   = (state == mwm_pkg::S_MUL);
    mul_last     = (cnt == STEP_W'(mwm_pkg::MUL_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mwm_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state_next != state) ? '0 : cnt + STEP_W'(1);
    end
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      coeff_x   <= 16'd256;
      coeff_y   <= 16'd256;
      coeff_rot <= 16'd256;
      max_drive <= 15'd32767;
      aux_mode  <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (mwm_pkg::reg_idx_t'(cfg.index))
        mwm_pkg::REG_COEFF_X:   coeff_x   <= cfg.data;
        mwm_pkg::REG_COEFF_Y:   coeff_y   <= cfg.data;
        mwm_pkg::REG_COEFF_ROT: coeff_rot <= cfg.data;
        mwm_pkg::REG_MAX_DRIVE: max_drive <= cfg.data[mwm_pkg::DRIVE_W-1:0];
        mwm_pkg::REG_AUX_MODE:  aux_mode  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- angle
  // heading mod 23040 into [0, 23040)
  always_comb begin
    head_s = mwm_pkg::HEAD_W'(drive.heading);
    if (head_s >= mwm_pkg::TURN_S) begin
      head_r = head_s - mwm_pkg::TURN_S;
    end else if (head_s >= 0) begin
      head_r = head_s;
    end else if (head_s >= -mwm_pkg::TURN_S) begin
      head_r = head_s + mwm_pkg::TURN_S;
    end else begin
      head_r = head_s + mwm_pkg::TURN2_S;
    end
  end

  // restoring division by 45, two quotient bits per cycle
  always_comb begin
    logic [mwm_pkg::REM_W:0] trial;
    div_rem = rem;
    div_dvd = dvd;
    div_quo = quo;
    for (int j = 0; j < mwm_pkg::DIV_DIGIT; j++) begin
      trial   = {div_rem, div_dvd[mwm_pkg::DVD_W-1]};
      div_dvd = div_dvd << 1;
      if (trial >= (mwm_pkg::REM_W + 1)'(mwm_pkg::ANGLE_DIV)) begin
        div_rem = mwm_pkg::REM_W'(trial - (mwm_pkg::REM_W + 1)'(mwm_pkg::ANGLE_DIV));
        div_quo = {div_quo[mwm_pkg::ANG_W-2:0], 1'b1};
      end else begin
        div_rem = trial[mwm_pkg::REM_W-1:0];
        div_quo = {div_quo[mwm_pkg::ANG_W-2:0], 1'b0};
      end
    end
  end

  // fold into [-90, 90] degrees; a half-turn shift is a flip of the sign bit
  always_comb begin
    t_ang    = signed'(quo);
    fold_neg = (t_ang > mwm_pkg::ANG_QUARTER) || (t_ang < -mwm_pkg::ANG_QUARTER);
    fold_z   = fold_neg ? {~t_ang[mwm_pkg::ANG_W-1], t_ang[mwm_pkg::ANG_W-2:0]} : t_ang;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_aux <= (drive.operation == mwm_pkg::OP_AUX);
      dvd    <= {head_r[mwm_pkg::U_W-1:0], {mwm_pkg::ANGLE_SHIFT{1'b0}}};
      rem    <= '0;
      quo    <= '0;
    end else if (state == mwm_pkg::S_DIV) begin
      dvd <= div_dvd;
      rem <= div_rem;
      quo <= div_quo;
    end
  end

  // ---------------------------------------------------------------- CORDIC
  assign atan_s = signed'(mwm_pkg::atan_angle(cnt[mwm_pkg::ATAN_IDX_W-1:0]));

  always_ff @(posedge clk) begin
    if (state == mwm_pkg::S_FOLD) begin
      x   <= mwm_pkg::CORDIC_X0;
      y   <= '0;
      z   <= fold_z;
      neg <= fold_neg;
    end else if (state == mwm_pkg::S_CORDIC) begin
      if (!z[mwm_pkg::ANG_W-1]) begin
        x <= x - (y >>> cnt);
        y <= y + (x >>> cnt);
        z <= z - atan_s;
      end else begin
        x <= x + (y >>> cnt);
        y <= y - (x >>> cnt);
        z <= z + atan_s;
      end
    end
  end

  always_comb begin
    x_f     = neg ? -x : x;
    y_f     = neg ? -y : y;
    cos_q15 = sat_q15(mwm_pkg::CQ_W'(x_f >>> mwm_pkg::Q15_SHIFT));
    sin_q15 = sat_q15(mwm_pkg::CQ_W'(y_f >>> mwm_pkg::Q15_SHIFT));
  end

  // ---------------------------------------------------------------- multipliers
  // shift-add, one multiplier bit per cycle; a signed multiplier takes its
  // top bit with negative weight
  always_comb begin
    logic signed [mwm_pkg::PROD_W-1:0] addend;
    for (int l = 0; l < LANES; l++) begin
      acc_next[l]   = acc[l];
      mcand_next[l] = mcand[l];
      mplr_next[l]  = mplr[l];
      addend        = mplr[l][0] ? mcand[l] : '0;
      if (lane_run) begin
        acc_next[l]   = (mul_signed && mul_last) ? acc[l] - addend : acc[l] + addend;
        mcand_next[l] = mcand[l] <<< 1;
        mplr_next[l]  = mplr[l] >> 1;
      end
    end
    if (accept_drive) begin
      for (int l = 0; l < LANES; l++) begin
        acc_next[l] = '0;
      end
      mcand_next[LANE_X] = mwm_pkg::PROD_W'(drive.speed);
      mcand_next[LANE_Y] = mwm_pkg::PROD_W'(drive.speed);
      mcand_next[LANE_W] = mwm_pkg::PROD_W'(drive.rotation);
      mplr_next[LANE_X]  = coeff_x;
      mplr_next[LANE_Y]  = coeff_y;
      mplr_next[LANE_W]  = coeff_rot;
    end
    if (state == mwm_pkg::S_SCALE) begin
      acc_next[LANE_X]   = '0;
      acc_next[LANE_Y]   = '0;
      mcand_next[LANE_X] = acc[LANE_X];
      mcand_next[LANE_Y] = acc[LANE_Y];
      mplr_next[LANE_X]  = unsigned'(cos_q15);
      mplr_next[LANE_Y]  = unsigned'(sin_q15);
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      acc[l]   <= acc_next[l];
      mcand[l] <= mcand_next[l];
      mplr[l]  <= mplr_next[l];
    end
  end

  // ---------------------------------------------------------------- mix
  always_comb begin
    s_fl =  mwm_pkg::SUM_W'(vx) + mwm_pkg::SUM_W'(vy) + mwm_pkg::SUM_W'(w);
    s_fr = -mwm_pkg::SUM_W'(vx) + mwm_pkg::SUM_W'(vy) - mwm_pkg::SUM_W'(w);
    s_rr =  mwm_pkg::SUM_W'(vx) + mwm_pkg::SUM_W'(vy) - mwm_pkg::SUM_W'(w);
    s_rl = -mwm_pkg::SUM_W'(vx) + mwm_pkg::SUM_W'(vy) + mwm_pkg::SUM_W'(w);
  end

  always_ff @(posedge clk) begin
    if (state == mwm_pkg::S_TRUNC) begin
      vx <= trunc_div(acc[LANE_X], 5'(mwm_pkg::FRAC_XY));
      vy <= trunc_div(acc[LANE_Y], 5'(mwm_pkg::FRAC_XY));
      w  <= trunc_div(acc[LANE_W], 5'(mwm_pkg::FRAC_ROT));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_fl <= '0;
      lw_fr <= '0;
      lw_rr <= '0;
      lw_rl <= '0;
    end else if (state == mwm_pkg::S_MIX) begin
      lw_fl <= clamp_wheel(s_fl, max_drive);
      lw_fr <= clamp_wheel(s_fr, max_drive);
      lw_rr <= clamp_wheel(s_rr, max_drive);
      lw_rl <= clamp_wheel(s_rl, max_drive);
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (fin_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      result.front_left  <= lw_fl;
      result.front_right <= lw_fr;
      result.rear_right  <= lw_rr;
      result.rear_left   <= lw_rl;
      result.aux_one     <= aux_of(lw_fl, aux_mode, op_aux);
      result.aux_two     <= aux_of(lw_fr, aux_mode, op_aux);
      result.aux_three   <= aux_of(lw_rr, aux_mode, op_aux);
      result.aux_four    <= aux_of(lw_rl, aux_mode, op_aux);
    end
  end

`ifndef ASSERT_OFF
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mwm_pkg::S_DIV) |-> (rem < mwm_pkg::REM_W'(mwm_pkg::ANGLE_DIV)))
    else $error("divider remainder out of range");

  a_drive_starts_div: assert property (@(posedge clk) disable iff (rst)
    (drive.valid && drive.ready && (drive.operation == mwm_pkg::OP_DRIVE))
    |=> (state == mwm_pkg::S_DIV))
    else $error("drive beat did not start the angle divider");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> ($past(state) == mwm_pkg::S_FIN))
    else $error("result raised outside the finish state");

  a_cordic_bound: assert property (@(posedge clk) disable iff (rst)
    (state == mwm_pkg::S_CORDIC) |-> (cnt < STEP_W'(CORDIC_STEPS)))
    else $error("CORDIC iteration count overrun");
`endif

endmodule

@@ test/mecanum_wheel_mixer_top_test.sv @@
`timescale 1ns / 1ps

module mecanum_wheel_mixer_top_test;
  import mwm_pkg::*;

  localparam int unsigned STEPS = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = STEPS + 80;
  localparam int HEAD_TURN = 23040;
  localparam int HEAD_QUARTER = 5760;
  localparam longint ANG_QUARTER_L = 64'sd1 << 30;
  localparam longint ANG_HALF_L = 64'sd1 << 31;
  localparam longint ANG_FULL_L = 64'sd1 << 32;
  localparam longint XY_SCALE = 64'sd1 << FRAC_XY;
  localparam longint ROT_SCALE = 64'sd1 << FRAC_ROT;
  localparam longint AUX_GAIN = -4;
  localparam int ARC_LEN = 24;

  typedef struct packed {
    op_t              op;
    logic [WHEEL_W-1:0] heading;
    logic [WHEEL_W-1:0] speed;
    logic [WHEEL_W-1:0] rotation;
    logic             hold;   // wait for every result before this beat
  } drive_item_t;

  typedef struct packed {
    logic [3:0][WHEEL_W-1:0] wheel;
    logic [3:0][AUX_W-1:0]   aux;
  } wheel_cmd_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mwm_drive_if  drive_bus();
  mwm_result_if result_bus();
  mwm_cfg_if    cfg_bus();

  mecanum_wheel_mixer_top #(.CORDIC_STEPS(STEPS)) u_top (
    .clk    (clk),
    .rst    (rst),
    .drive  (drive_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  always #5 clk = ~clk;

  // atan(2^-i) as a binary angle, full turn = 2^32
  logic [31:0] arc_tab [ARC_LEN] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43, 32'h0145_D7E1,
    32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
    32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C, 32'h0000_28BE, 32'h0000_145F,
    32'h0000_0A2F, 32'h0000_0517, 32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
  };

  string wheel_names [4] = '{"front_left", "front_right", "rear_right", "rear_left"};
  string aux_names [4] = '{"aux_one", "aux_two", "aux_three", "aux_four"};

  // mirror of the block's registers and stored wheel commands
  logic [COEFF_W-1:0] gain_x = 16'd256;
  logic [COEFF_W-1:0] gain_y = 16'd256;
  logic [COEFF_W-1:0] gain_rot = 16'd256;
  logic [DRIVE_W-1:0] drive_cap = 15'h7FFF;
  logic               aux_on = 1'b0;
  longint             wheel_mem [4] = '{0, 0, 0, 0};

  drive_item_t drive_queue [$];
  wheel_cmd_t  expected_cmds [$];
  reg_write_t  reg_writes [$];
  drive_item_t in_flight;
  int          src_gap_pct = 0;
  int          sink_stall_pct = 0;
  int          n_fail = 0;
  int          quiet_cycles = 0;

  function automatic longint clip_q15(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // heading in 1/64 degree -> Q1.15 cos/sin via rotation-mode CORDIC
  function automatic void heading_to_cos_sin(input logic [WHEEL_W-1:0] heading,
                                             output longint c, output longint s);
    int     u;
    longint t, x, y, nx;
    logic   flip;
    u = int'($signed(heading)) % HEAD_TURN;
    if (u < 0) u += HEAD_TURN;
    t = (longint'(u) << 32) / HEAD_TURN;
    if (t >= ANG_HALF_L) t -= ANG_FULL_L;
    flip = 1'b0;
    if (t > ANG_QUARTER_L) begin
      t -= ANG_HALF_L;
      flip = 1'b1;
    end else if (t < -ANG_QUARTER_L) begin
      t += ANG_HALF_L;
      flip = 1'b1;
    end
    x = longint'(CORDIC_X0);
    y = 0;
    for (int i = 0; i < STEPS && i < ARC_LEN; i++) begin
      if (t >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        t -= longint'(arc_tab[i]);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        t += longint'(arc_tab[i]);
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = clip_q15(x >>> Q15_SHIFT);
    s = clip_q15(y >>> Q15_SHIFT);
  endfunction

  function automatic wheel_cmd_t mix_wheels(input drive_item_t it);
    longint     c, s, vx, vy, w, spd;
    longint     sum [4];
    longint     aux_v [4];
    wheel_cmd_t r;
    if (it.op == OP_DRIVE) begin
      heading_to_cos_sin(it.heading, c, s);
      spd = longint'($signed(it.speed));
      vx = (longint'(gain_x) * spd * c) / XY_SCALE;
      vy = (longint'(gain_y) * spd * s) / XY_SCALE;
      w = (longint'(gain_rot) * longint'($signed(it.rotation))) / ROT_SCALE;
      sum[0] = vx + vy + w;
      sum[1] = -vx + vy - w;
      sum[2] = vx + vy - w;
      sum[3] = -vx + vy + w;
      for (int k = 0; k < 4; k++) begin
        if (sum[k] > longint'(drive_cap)) sum[k] = longint'(drive_cap);
        if (sum[k] < -32768) sum[k] = -32768;
        wheel_mem[k] = sum[k];
        aux_v[k] = aux_on ? AUX_GAIN * sum[k] : 0;
      end
    end else begin
      for (int k = 0; k < 4; k++) aux_v[k] = aux_on ? longint'(AUX_FIXED) : 0;
    end
    for (int k = 0; k < 4; k++) begin
      r.wheel[k] = WHEEL_W'(wheel_mem[k]);
      r.aux[k] = AUX_W'(aux_v[k]);
    end
    return r;
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_COEFF_X:   gain_x = data;
      REG_COEFF_Y:   gain_y = data;
      REG_COEFF_ROT: gain_rot = data;
      REG_MAX_DRIVE: drive_cap = data[DRIVE_W-1:0];
      REG_AUX_MODE:  aux_on = data[0];
      default: ;
    endcase
  endfunction

  // drive channel
  always @(posedge clk) begin
    if (rst) begin
      drive_bus.valid <= 1'b0;
    end else begin
      if (drive_bus.valid && drive_bus.ready) begin
        expected_cmds.push_back(mix_wheels(in_flight));
      end
      if (!drive_bus.valid || drive_bus.ready) begin
        if (drive_queue.size() != 0 && (!drive_queue[0].hold || expected_cmds.size() == 0) &&
            $urandom_range(99) >= src_gap_pct) begin
          in_flight = drive_queue.pop_front();
          drive_bus.valid <= 1'b1;
          drive_bus.operation <= in_flight.op;
          drive_bus.heading <= in_flight.heading;
          drive_bus.speed <= in_flight.speed;
          drive_bus.rotation <= in_flight.rotation;
        end else begin
          drive_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result channel, checker and watchdog
  always @(posedge clk) begin
    wheel_cmd_t got, want;
    if (rst) begin
      result_bus.ready <= 1'b0;
      quiet_cycles = 0;
    end else begin
      if (result_bus.valid && result_bus.ready) begin
        got.wheel[0] = result_bus.front_left;
        got.wheel[1] = result_bus.front_right;
        got.wheel[2] = result_bus.rear_right;
        got.wheel[3] = result_bus.rear_left;
        got.aux[0] = result_bus.aux_one;
        got.aux[1] = result_bus.aux_two;
        got.aux[2] = result_bus.aux_three;
        got.aux[3] = result_bus.aux_four;
        if (expected_cmds.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          n_fail++;
        end else begin
          want = expected_cmds.pop_front();
          for (int k = 0; k < 4; k++) begin
            if (got.wheel[k] !== want.wheel[k]) begin
              $display("%0t: %s expected %0d actual %0d", $time, wheel_names[k],
                       $signed(want.wheel[k]), $signed(got.wheel[k]));
              n_fail++;
            end
            if (got.aux[k] !== want.aux[k]) begin
              $display("%0t: %s expected %0d actual %0d", $time, aux_names[k],
                       $signed(want.aux[k]), $signed(got.aux[k]));
              n_fail++;
            end
          end
        end
      end
      if ((result_bus.valid && result_bus.ready) || (drive_bus.valid && drive_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      result_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic push_item(input op_t op, input int h, input int s, input int r,
                           input logic hold);
    drive_item_t it;
    it.op = op;
    it.heading = WHEEL_W'(h);
    it.speed = WHEEL_W'(s);
    it.rotation = WHEEL_W'(r);
    it.hold = hold;
    drive_queue.push_back(it);
  endtask

  function automatic int pick_level();
    int corner [5] = '{-32768, 32767, 0, -1, 1};
    if ($urandom_range(99) < 15) return corner[$urandom_range(4)];
    return int'($signed(WHEEL_W'($urandom)));
  endfunction

  function automatic int pick_heading();
    case ($urandom_range(9))
      0, 1, 2, 3: return int'($signed(WHEEL_W'($urandom)));
      4, 5, 6:    return int'($urandom_range(2 * HEAD_TURN)) - HEAD_TURN;
      default:    return (int'($urandom_range(8)) - 4) * HEAD_QUARTER +
                         int'($urandom_range(8)) - 4;
    endcase
  endfunction

  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    reg_writes.push_back(w);
  endtask

  task automatic program_regs();
    reg_write_t w;
    @(posedge clk);
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_bus.index <= w.idx;
      cfg_bus.data <= w.data;
      cfg_bus.valid <= 1'b1;
      do @(posedge clk); while (!cfg_bus.ready);
      apply_reg(w.idx, w.data);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (drive_queue.size() != 0 || drive_bus.valid || expected_cmds.size() != 0);
  endtask

  task automatic run_random(input int n, input int gap, input int stall);
    @(negedge clk);
    src_gap_pct = gap;
    sink_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      push_item(($urandom_range(99) < 20) ? OP_AUX : OP_DRIVE, pick_heading(), pick_level(),
                pick_level(), $urandom_range(99) < 3);
    end
    wait_drained();
  endtask

  initial begin
    drive_bus.valid = 1'b0;
    drive_bus.operation = OP_DRIVE;
    drive_bus.heading = '0;
    drive_bus.speed = '0;
    drive_bus.rotation = '0;
    result_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings
    @(negedge clk);
    src_gap_pct = 12;
    sink_stall_pct = 65;
    push_item(OP_AUX, 123, -456, 789, 1'b0);   // stored commands still zero
    push_item(OP_DRIVE, 0, 32767, 0, 1'b0);
    push_item(OP_DRIVE, HEAD_QUARTER, 32767, 0, 1'b0);
    push_item(OP_DRIVE, 2 * HEAD_QUARTER, -32768, 0, 1'b0);
    push_item(OP_DRIVE, -HEAD_QUARTER, 20000, 100, 1'b0);
    push_item(OP_DRIVE, -2 * HEAD_QUARTER, 20000, -100, 1'b0);
    push_item(OP_DRIVE, 3 * HEAD_QUARTER, 15000, -1, 1'b0);
    push_item(OP_DRIVE, HEAD_TURN, 1000, 0, 1'b0);     // wraps to zero
    push_item(OP_DRIVE, -HEAD_TURN, -1000, 0, 1'b0);
    push_item(OP_DRIVE, 32767, 32767, 32767, 1'b0);
    push_item(OP_DRIVE, -32768, -32768, -32768, 1'b0);
    push_item(OP_AUX, -1, -1, -1, 1'b0);                // repeats last drive
    push_item(OP_DRIVE, HEAD_QUARTER / 2, 32767, 32767, 1'b0);
    push_item(OP_DRIVE, HEAD_QUARTER + 1, 30000, 0, 1'b0);
    push_item(OP_DRIVE, HEAD_QUARTER - 1, 30000, 0, 1'b0);
    push_item(OP_DRIVE, -HEAD_QUARTER - 1, -30000, 0, 1'b0);
    push_item(OP_DRIVE, 0, 0, 32767, 1'b0);
    push_item(OP_DRIVE, 0, 0, -32768, 1'b0);
    push_item(OP_DRIVE, 1, -1, 1, 1'b0);                // tiny speed truncates to zero
    push_item(OP_DRIVE, 5 * HEAD_QUARTER, -3, -255, 1'b0);
    push_item(OP_AUX, 0, 0, 0, 1'b1);
    wait_drained();

    // random settings, writes to unused indexes must be ignored
    queue_reg(REG_COEFF_X, CFG_DATA_W'($urandom));
    queue_reg(REG_COEFF_Y, CFG_DATA_W'($urandom));
    queue_reg(REG_COEFF_ROT, CFG_DATA_W'($urandom));
    queue_reg(REG_MAX_DRIVE, CFG_DATA_W'($urandom));
    queue_reg(REG_AUX_MODE, CFG_DATA_W'($urandom) | 16'h0001);
    for (int i = REG_AUX_MODE + 1; i < (1 << CFG_IDX_W); i++)
      queue_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    program_regs();
    run_random(200, 12, 65);

    // largest gains; max_drive bit 15 is dropped
    queue_reg(REG_COEFF_X, 16'hFFFF);
    queue_reg(REG_COEFF_Y, 16'hFFFF);
    queue_reg(REG_COEFF_ROT, 16'hFFFF);
    queue_reg(REG_MAX_DRIVE, 16'hFFFF);
    queue_reg(REG_AUX_MODE, 16'hFFFF);
    program_regs();
    run_random(200, 65, 12);

    // zero gains, zero clamp, aux mode off through a masked write
    queue_reg(REG_COEFF_X, 16'h0000);
    queue_reg(REG_COEFF_Y, 16'h0000);
    queue_reg(REG_COEFF_ROT, 16'h0000);
    queue_reg(REG_MAX_DRIVE, 16'h0000);
    queue_reg(REG_AUX_MODE, 16'hFFFE);
    program_regs();
    run_random(150, 65, 12);

    // random gains with a low clamp
    queue_reg(REG_COEFF_X, CFG_DATA_W'($urandom));
    queue_reg(REG_COEFF_Y, CFG_DATA_W'($urandom));
    queue_reg(REG_COEFF_ROT, CFG_DATA_W'($urandom));
    queue_reg(REG_MAX_DRIVE, CFG_DATA_W'($urandom_range(4000)));
    queue_reg(REG_AUX_MODE, 16'h0001);
    program_regs();
    run_random(200, 0, 0);

    // unit gains, full clamp
    queue_reg(REG_COEFF_X, 16'd256);
    queue_reg(REG_COEFF_Y, 16'd256);
    queue_reg(REG_COEFF_ROT, 16'd256);
    queue_reg(REG_MAX_DRIVE, 16'h7FFF);
    for (int i = REG_AUX_MODE + 1; i < (1 << CFG_IDX_W); i++)
      queue_reg(CFG_IDX_W'(i), 16'h0000);
    program_regs();
    run_random(200, 0, 0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (n_fail == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
